// ----- rtl/clt_pkg.sv -----
`timescale 1ns / 1ps

package clt_pkg;

  localparam int MaxRunDefault = 31;

  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_e;

  // What is left of an item's result list after the head word goes out.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SLASH = 2'd1,
    KIND_ITEM  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_e;

  typedef struct packed {
    logic accept;
    logic cfg_write;
    logic pop;
    logic out_take;
  } cmd_t;

  typedef struct packed {
    logic  out_valid;
    kind_e rem_kind;
  } status_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

// ----- rtl/clt_ctrl.sv -----
`timescale 1ns / 1ps

module clt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  clt_pkg::status_t status_i,
  output clt_pkg::cmd_t    cmd_o
);
  import clt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SLASH = 4'b0010,
    ST_ITEM  = 4'b0100,
    ST_CLOSE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   idle;
  logic   out_free;
  logic   accept;

  assign idle     = (state_q == ST_IDLE);
  assign out_free = !status_i.out_valid || out_ready_i;

  // A new item is taken only when nothing of the previous one is left to emit.
  assign cfg_ready_o = idle;
  assign in_ready_o  = idle && out_free && !cfg_valid_i;
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.accept    = accept;
  assign cmd_o.cfg_write = cfg_valid_i && idle;
  assign cmd_o.pop       = out_free && (!idle || accept);
  assign cmd_o.out_take  = status_i.out_valid && out_ready_i;

  always_comb begin
    state_d = state_q;
    if (cmd_o.pop) begin
      unique case (status_i.rem_kind)
        KIND_NONE:  state_d = ST_IDLE;
        KIND_SLASH: state_d = ST_SLASH;
        KIND_ITEM:  state_d = ST_ITEM;
        KIND_CLOSE: state_d = ST_CLOSE;
        default:    state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/clt_datapath.sv -----
`timescale 1ns / 1ps

module clt_datapath #(
  parameter int MAX_RUN = clt_pkg::MaxRunDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clt_pkg::cmd_t    cmd_i,
  output clt_pkg::status_t status_o,
  input  logic [7:0]       char_in_i,
  input  logic             has_char_i,
  input  logic             end_of_line_i,
  input  logic             split_mode_i,
  output logic [7:0]       char_out_o,
  output logic             char_valid_o,
  output logic             token_end_o,
  output logic             run_last_o,
  output logic             slash_overflow_o,
  output logic             out_valid_o
);
  import clt_pkg::*;

  localparam int RunW = $clog2(MAX_RUN + 1);

  // Line state.
  logic            mode_q, mode_d;
  logic            phase_q, phase_d;
  quote_e          quote_q, quote_d;
  logic            esc_q, esc_d;
  logic            clp_q, clp_d;
  logic [RunW-1:0] run_q, run_d;
  logic            ovf_q, ovf_d;

  // Results of the accepted item: a run of backslashes, then an optional
  // byte or token end, then an optional closing token end.
  logic [RunW-1:0] f_cnt;
  logic            f_item, f_item_end, f_close;
  logic [7:0]      f_byte;

  // Results still owed for the current item.
  logic [RunW-1:0] cnt_q, cnt_d;
  logic            item_q, item_d;
  logic            item_end_q, item_end_d;
  logic [7:0]      byte_q, byte_d;
  logic            close_q, close_d;

  logic            head_valid, head_char, head_end;
  logic [7:0]      head_byte;
  kind_e           rem_kind;

  logic [7:0]      out_char_q;
  logic            out_cv_q, out_end_q, out_last_q, out_ovf_q, out_valid_q;

  always_comb begin
    logic            ws;
    logic            done;
    logic [RunW-1:0] n;
    mode_d     = mode_q;
    phase_d    = phase_q;
    quote_d    = quote_q;
    esc_d      = esc_q;
    clp_d      = clp_q;
    run_d      = run_q;
    ovf_d      = ovf_q;
    f_cnt      = '0;
    f_item     = 1'b0;
    f_item_end = 1'b0;
    f_byte     = char_in_i;
    f_close    = 1'b0;
    ws         = is_space(char_in_i);
    done       = 1'b0;
    n          = run_q;

    if (cmd_i.accept) begin
      if (has_char_i) begin
        if (!mode_q) begin
          if (esc_q) begin
            esc_d  = 1'b0;
            f_item = 1'b1;
          end else if (quote_q != QUOTE_NONE) begin
            if (char_in_i == ((quote_q == QUOTE_SINGLE) ? ChSq : ChDq)) begin
              quote_d = QUOTE_NONE;
            end else if (char_in_i == ChBsl && quote_q == QUOTE_DOUBLE) begin
              esc_d = 1'b1;
            end else begin
              f_item = 1'b1;
            end
          end else if (phase_q || !ws) begin
            phase_d = 1'b1;
            if (ws) begin
              f_item     = 1'b1;
              f_item_end = 1'b1;
              f_byte     = '0;
              phase_d    = 1'b0;
            end else if (char_in_i == ChSq) begin
              quote_d = QUOTE_SINGLE;
            end else if (char_in_i == ChDq) begin
              quote_d = QUOTE_DOUBLE;
            end else if (char_in_i == ChBsl) begin
              esc_d = 1'b1;
            end else begin
              f_item = 1'b1;
            end
          end
        end else begin
          // A quote inside quotes waits one byte to see whether it is doubled.
          if (clp_q) begin
            clp_d = 1'b0;
            if (char_in_i == ChDq) begin
              f_item = 1'b1;
              done   = 1'b1;
            end else begin
              quote_d = QUOTE_NONE;
            end
          end
          if (!done && run_q != '0) begin
            if (char_in_i == ChBsl) begin
              if (run_q < RunW'(MAX_RUN)) begin
                run_d = run_q + RunW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              done = 1'b1;
            end else begin
              run_d = '0;
              if (char_in_i == ChDq) begin
                f_cnt = n >> 1;
                if (!n[0]) begin
                  quote_d = (quote_d != QUOTE_NONE) ? QUOTE_NONE : QUOTE_DOUBLE;
                end else begin
                  f_item = 1'b1;
                end
                done = 1'b1;
              end else begin
                f_cnt = n;
              end
            end
          end
          if (!done && (phase_q || !ws)) begin
            phase_d = 1'b1;
            if (quote_d == QUOTE_NONE && ws) begin
              f_item     = 1'b1;
              f_item_end = 1'b1;
              f_byte     = '0;
              phase_d    = 1'b0;
            end else if (char_in_i == ChBsl) begin
              run_d = RunW'(1);
            end else if (char_in_i == ChDq) begin
              if (quote_d != QUOTE_NONE) begin
                clp_d = 1'b1;
              end else begin
                quote_d = QUOTE_DOUBLE;
              end
            end else begin
              f_item = 1'b1;
            end
          end
        end
      end
      // Backslashes flushed at the end of line only occur when the byte
      // itself produced nothing, so they can lead the result list.
      if (end_of_line_i) begin
        if (!mode_q) begin
          if (esc_d) begin
            f_cnt = RunW'(1);
          end
        end else if (run_d != '0) begin
          f_cnt = run_d;
        end
        f_close = phase_d;
        phase_d = 1'b0;
        quote_d = QUOTE_NONE;
        esc_d   = 1'b0;
        clp_d   = 1'b0;
        run_d   = '0;
      end
    end

    if (cmd_i.cfg_write) begin
      mode_d  = split_mode_i;
      phase_d = 1'b0;
      quote_d = QUOTE_NONE;
      esc_d   = 1'b0;
      clp_d   = 1'b0;
      run_d   = '0;
    end
  end

  // Pick the next result word from the fresh list or the stored remainder.
  always_comb begin
    logic [RunW-1:0] s_cnt;
    logic            s_item, s_item_end, s_close;
    logic [7:0]      s_byte;
    s_cnt      = cmd_i.accept ? f_cnt      : cnt_q;
    s_item     = cmd_i.accept ? f_item     : item_q;
    s_item_end = cmd_i.accept ? f_item_end : item_end_q;
    s_byte     = cmd_i.accept ? f_byte     : byte_q;
    s_close    = cmd_i.accept ? f_close    : close_q;

    cnt_d      = s_cnt;
    item_d     = s_item;
    item_end_d = s_item_end;
    byte_d     = s_byte;
    close_d    = s_close;
    head_valid = 1'b1;
    head_char  = 1'b1;
    head_end   = 1'b0;
    head_byte  = ChBsl;

    if (s_cnt != '0) begin
      cnt_d = s_cnt - RunW'(1);
    end else if (s_item) begin
      item_d    = 1'b0;
      head_char = !s_item_end;
      head_end  = s_item_end;
      head_byte = s_byte;
    end else if (s_close) begin
      close_d   = 1'b0;
      head_char = 1'b0;
      head_end  = 1'b1;
      head_byte = '0;
    end else begin
      head_valid = 1'b0;
      head_char  = 1'b0;
      head_byte  = '0;
    end

    if (cnt_d != '0) begin
      rem_kind = KIND_SLASH;
    end else if (item_d) begin
      rem_kind = KIND_ITEM;
    end else if (close_d) begin
      rem_kind = KIND_CLOSE;
    end else begin
      rem_kind = KIND_NONE;
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign status_o.rem_kind  = rem_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      phase_q     <= 1'b0;
      quote_q     <= QUOTE_NONE;
      esc_q       <= 1'b0;
      clp_q       <= 1'b0;
      run_q       <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      item_q      <= 1'b0;
      item_end_q  <= 1'b0;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      quote_q <= quote_d;
      esc_q   <= esc_d;
      clp_q   <= clp_d;
      run_q   <= run_d;
      ovf_q   <= ovf_d;
      if (cmd_i.pop) begin
        cnt_q      <= cnt_d;
        item_q     <= item_d;
        item_end_q <= item_end_d;
        close_q    <= close_d;
      end
      if (cmd_i.pop && head_valid) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      byte_q <= byte_d;
    end
    if (cmd_i.pop && head_valid) begin
      out_char_q <= head_byte;
      out_cv_q   <= head_char;
      out_end_q  <= head_end;
      out_last_q <= (rem_kind == KIND_NONE);
      out_ovf_q  <= ovf_d;
    end
  end

  assign char_out_o       = out_char_q;
  assign char_valid_o     = out_cv_q;
  assign token_end_o      = out_end_q;
  assign run_last_o       = out_last_q;
  assign slash_overflow_o = out_ovf_q;
  assign out_valid_o      = out_valid_q;

endmodule

// ----- rtl/command_line_tokenizer.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Word
// in       input      in_valid_i/in_ready_o  char_in_i, has_char_i, end_of_line_i
// out      output     out_valid_o/out_ready_i char_out_o, char_valid_o, token_end_o,
//                                            run_last_o, slash_overflow_o
// cfg      input      cfg_valid_i/cfg_ready_o split_mode_i
//
// The first result of an input word is loaded into the output register in the cycle
// the word is taken, and each further result (mostly a buffered backslash run) is
// loaded in turn as the output register frees. Input is stalled while results of
// the previous word remain, while a configuration write waits, or while the output
// register holds a word that is not being taken. Reset is asynchronous, active
// low, and leaves the block idle in shell mode with no token open.
module command_line_tokenizer #(
  parameter int MAX_RUN = clt_pkg::MaxRunDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       has_char_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  output logic       char_valid_o,
  output logic       token_end_o,
  output logic       run_last_o,
  output logic       slash_overflow_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       split_mode_i
);
  import clt_pkg::*;

  cmd_t    cmd;
  status_t status;

  clt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clt_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .char_in_i        (char_in_i),
    .has_char_i       (has_char_i),
    .end_of_line_i    (end_of_line_i),
    .split_mode_i     (split_mode_i),
    .char_out_o       (char_out_o),
    .char_valid_o     (char_valid_o),
    .token_end_o      (token_end_o),
    .run_last_o       (run_last_o),
    .slash_overflow_o (slash_overflow_o),
    .out_valid_o      (out_valid_o)
  );

  // A word still waiting when new input is taken must close the previous item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o |-> run_last_o)
    else $error("input taken while earlier results are still owed");

  // Every result is either a byte or a token end, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_valid_o ^ token_end_o))
    else $error("result word is neither a byte nor a token end");

  // The overflow flag never falls once it has been shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && slash_overflow_o |=> !out_valid_o || slash_overflow_o)
    else $error("sticky overflow flag dropped");

  // A token end carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_end_o |-> (char_out_o == 8'h00) && !char_valid_o)
    else $error("token end carries a byte");

endmodule
